// File: rtl/assert_macros.svh
// Assertion macros used by the walker RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define SV39_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication, disabled while reset is high.
`define SV39_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define SV39_ASSERT_IMPL(name, clk, rst, ante, cons)
`define SV39_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// File: rtl/sv39ptw_pkg.sv
// Shared types and constants of the Sv39 page-table walker.
// No dependencies; imported by every other file of the block but assert_macros.svh.
package sv39ptw_pkg;

   // Table store geometry
   localparam int PAGES   = 16;
   localparam int SLOTS   = 512;
   localparam int IDX_W   = 9;
   localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int ADDR_W  = PAGE_W + IDX_W;
   localparam int DEPTH   = PAGES * SLOTS;
   localparam int CMP_W   = 9;

   // Field widths
   localparam int PGNUM_W = 4;
   localparam int ROOT_W  = 8;
   localparam int VA_W    = 39;
   localparam int PTE_W   = 64;
   localparam int PA_W    = 56;
   localparam int PPN_W   = 44;
   localparam int LEVEL_W = 2;

   // PTE bit positions
   localparam int PTE_V   = 0;
   localparam int PTE_R   = 1;
   localparam int PTE_W_B = 2;
   localparam int PTE_X   = 3;
   localparam int PTE_G   = 5;
   localparam int PPN_LSB = 10;

   // Walk levels
   localparam logic [LEVEL_W-1:0] LVL_4KB = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_2MB = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_1GB = 2'd2;

   // Request kinds on the input channel
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_XLATE = 1'b1;

   // Command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_WALK,
      CMD_FAULT
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [PAGE_W-1:0]      page;   // write page, or root page of a walk
      logic [IDX_W-1:0]       index;
      logic [PTE_W-1:0]       value;
      logic [VA_W-1:0]        va;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } walk_state_type;

endpackage

// File: rtl/sv39ptw_ifs.sv
// Request and response channel interfaces of the page-table walker.
// Depends on sv39ptw_pkg for field widths.
interface sv39ptw_req_if;
   import sv39ptw_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [PGNUM_W-1:0]   page_number;
   logic [IDX_W-1:0]     entry_index;
   logic [PTE_W-1:0]     entry_value;
   logic [VA_W-1:0]      virtual_address;

   modport source (output valid, kind, page_number, entry_index, entry_value,
                   virtual_address, input ready);
   modport sink   (input valid, kind, page_number, entry_index, entry_value,
                   virtual_address, output ready);
endinterface

interface sv39ptw_rsp_if;
   import sv39ptw_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 fault;
   logic [PA_W-1:0]      physical_address;
   logic                 global_page;
   logic [LEVEL_W-1:0]   leaf_level;

   modport source (output valid, fault, physical_address, global_page, leaf_level,
                   input ready);
   modport sink   (input valid, fault, physical_address, global_page, leaf_level,
                   output ready);
endinterface

// File: rtl/sv39_page_table_walker.sv
// Sv39 page-table walker with a private table store (PAGES x 512 entries).
// After acceptance: a write is queued, then written when the engine pops it; a translate reads
// one entry per level (none for a root beyond the store), then loads the response register.
// Throughput: one write per cycle while the engine is idle; translates do not overlap.
// Reset: synchronous; then all PAGES*512 = 8192 entries are cleared, requests held off.
module sv39_page_table_walker (
   input  logic                             clock,
   input  logic                             reset,
   sv39ptw_req_if.sink                      req_if,
   sv39ptw_rsp_if.source                    rsp_if,
   input  logic                             csr_wr_en,
   input  logic [sv39ptw_pkg::ROOT_W-1:0]   csr_wr_data
);
   import sv39ptw_pkg::*;

   logic              q_push;
   item_type          q_item;
   logic              q_pop;
   item_type          q_head;
   queue_status_type  q_status;
   logic              clearing;

   sv39ptw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .clearing    (clearing),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_item      (q_item)
   );

   sv39ptw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   sv39ptw_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_status (q_status),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp_if   (rsp_if)
   );

endmodule

// File: rtl/sv39ptw_front.sv
// Front end: takes requests, holds the root register, classifies commands.
// Depends on sv39ptw_pkg and sv39ptw_req_if.
module sv39ptw_front (
   input  logic                             clock,
   input  logic                             reset,
   sv39ptw_req_if.sink                      req_if,
   input  logic                             csr_wr_en,
   input  logic [sv39ptw_pkg::ROOT_W-1:0]   csr_wr_data,
   input  logic                             clearing,
   input  sv39ptw_pkg::queue_status_type    q_status,
   output logic                             q_push,
   output sv39ptw_pkg::item_type            q_item
);
   import sv39ptw_pkg::*;

   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W-1:0] root_in;
   logic              accept;
   logic              wr_in_store;
   logic              root_in_store;

   // Root page register
   always_comb begin
      root_in = root_ff;
      if (csr_wr_en) begin
         root_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   // Hold off requests while the store is being cleared or the queue is full
   assign req_if.ready = !q_status.full && !clearing;
   assign accept       = req_if.valid && req_if.ready;

   assign wr_in_store   = CMP_W'(req_if.page_number) < CMP_W'(PAGES);
   assign root_in_store = CMP_W'(root_ff) < CMP_W'(PAGES);

   // Classify: writes outside the store are dropped here
   always_comb begin
      q_item.index = req_if.entry_index;
      q_item.value = req_if.entry_value;
      q_item.va    = req_if.virtual_address;
      if (req_if.kind == KIND_WRITE) begin
         q_item.cmd  = CMD_WRITE;
         q_item.page = PAGE_W'(req_if.page_number);
         q_push      = accept && wr_in_store;
      end else begin
         q_item.cmd  = root_in_store ? CMD_WALK : CMD_FAULT;
         q_item.page = PAGE_W'(root_ff);
         q_push      = accept;
      end
   end

endmodule

// File: rtl/sv39ptw_queue.sv
// Short command queue between front end and walk engine.
// Depends on sv39ptw_pkg for the item type and depth.
module sv39ptw_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  sv39ptw_pkg::item_type          push_item,
   input  logic                           pop,
   output sv39ptw_pkg::item_type          head,
   output sv39ptw_pkg::queue_status_type  status
);
   import sv39ptw_pkg::*;

   item_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign status.full  = count_ff == QCNT_W'(QDEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/sv39ptw_back.sv
// Walk engine: owns the table store, runs writes and level-by-level walks,
// and holds the response register. Depends on sv39ptw_pkg and sv39ptw_rsp_if.
`include "assert_macros.svh"

module sv39ptw_back (
   input  logic                           clock,
   input  logic                           reset,
   input  sv39ptw_pkg::item_type          head,
   input  sv39ptw_pkg::queue_status_type  q_status,
   output logic                           q_pop,
   output logic                           clearing,
   sv39ptw_rsp_if.source                  rsp_if
);
   import sv39ptw_pkg::*;

   // Table store, one write and one registered read per cycle
   logic [PTE_W-1:0]    mem [DEPTH];
   logic [PTE_W-1:0]    rd_data_ff;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [PTE_W-1:0]    wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;

   walk_state_type      state_ff;
   walk_state_type      state_in;
   logic [ADDR_W-1:0]   clr_ff;
   logic [ADDR_W-1:0]   clr_in;
   logic [LEVEL_W-1:0]  level_ff;
   logic [LEVEL_W-1:0]  level_in;
   logic [VA_W-1:0]     va_ff;
   logic [VA_W-1:0]     va_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_fault_ff;
   logic [PA_W-1:0]     rsp_pa_ff;
   logic                rsp_g_ff;
   logic [LEVEL_W-1:0]  rsp_level_ff;
   logic                rsp_load;
   logic                ld_fault;
   logic [PA_W-1:0]     ld_pa;
   logic                ld_g;
   logic [LEVEL_W-1:0]  ld_level;
   logic                out_free;

   // Decoded entry
   logic [PPN_W-1:0]    ppn;
   logic                pte_v;
   logic                pte_r;
   logic                pte_w;
   logic                pte_x;
   logic                is_ptr;
   logic                descend;
   logic                aligned;
   logic                leaf_ok;
   logic [PA_W-1:0]     leaf_pa;

   function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                 input logic [LEVEL_W-1:0] lvl);
      logic [IDX_W-1:0] ix;
      case (lvl)
         LVL_1GB: ix = va[38:30];
         LVL_2MB: ix = va[29:21];
         default: ix = va[20:12];
      endcase
      return ix;
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Entry decode for the level under evaluation
   assign ppn     = rd_data_ff[PPN_LSB +: PPN_W];
   assign pte_v   = rd_data_ff[PTE_V];
   assign pte_r   = rd_data_ff[PTE_R];
   assign pte_w   = rd_data_ff[PTE_W_B];
   assign pte_x   = rd_data_ff[PTE_X];
   assign is_ptr  = pte_v && !pte_r && !pte_w && !pte_x;
   assign descend = is_ptr && (level_ff != LVL_4KB) && (ppn < PPN_W'(PAGES));
   assign leaf_ok = pte_v && !is_ptr && !(!pte_r && pte_w) && aligned;

   always_comb begin
      case (level_ff)
         LVL_1GB: begin
            aligned = ppn[17:0] == '0;
            leaf_pa = {ppn[43:18], va_ff[29:0]};
         end
         LVL_2MB: begin
            aligned = ppn[8:0] == '0;
            leaf_pa = {ppn[43:9], va_ff[20:0]};
         end
         default: begin
            aligned = 1'b1;
            leaf_pa = {ppn, va_ff[11:0]};
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign clearing = state_ff == ST_CLEAR;

   // Walk sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      level_in = level_ff;
      va_in    = va_ff;
      wr_en    = 1'b0;
      wr_addr  = clr_ff;
      wr_data  = '0;
      rd_en    = 1'b0;
      rd_addr  = {head.page, va_index(head.va, LVL_1GB)};
      q_pop    = 1'b0;
      rsp_load = 1'b0;
      ld_fault = 1'b1;
      ld_pa    = '0;
      ld_g     = 1'b0;
      ld_level = LVL_4KB;
      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               case (head.cmd)
                  CMD_WRITE: begin
                     wr_en   = 1'b1;
                     wr_addr = {head.page, head.index};
                     wr_data = head.value;
                     q_pop   = 1'b1;
                  end
                  CMD_WALK: begin
                     rd_en    = 1'b1;
                     va_in    = head.va;
                     level_in = LVL_1GB;
                     q_pop    = 1'b1;
                     state_in = ST_LOOK;
                  end
                  CMD_FAULT: begin
                     if (out_free) begin
                        rsp_load = 1'b1;
                        q_pop    = 1'b1;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (descend) begin
               rd_en    = 1'b1;
               rd_addr  = {ppn[PAGE_W-1:0], va_index(va_ff, level_ff - LEVEL_W'(1))};
               level_in = level_ff - LEVEL_W'(1);
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (leaf_ok) begin
                  ld_fault = 1'b0;
                  ld_pa    = leaf_pa;
                  ld_g     = rd_data_ff[PTE_G];
                  ld_level = level_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      va_ff    <= va_in;
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_fault_ff <= ld_fault;
         rsp_pa_ff    <= ld_pa;
         rsp_g_ff     <= ld_g;
         rsp_level_ff <= ld_level;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.fault            = rsp_fault_ff;
   assign rsp_if.physical_address = rsp_pa_ff;
   assign rsp_if.global_page      = rsp_g_ff;
   assign rsp_if.leaf_level       = rsp_level_ff;

   // Checks
   `SV39_ASSERT_IMPL(a_fault_clean, clock, reset, rsp_valid_ff && rsp_fault_ff, rsp_pa_ff == '0 && !rsp_g_ff && rsp_level_ff == LVL_4KB)
   `SV39_ASSERT_IMPL(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, !q_pop && !rsp_valid_ff)
   `SV39_ASSERT_IMPL(a_descend_lvl, clock, reset, state_ff == ST_LOOK && rd_en, level_ff != LVL_4KB)
   `SV39_ASSERT_NEXT(a_walk_start, clock, reset, state_ff == ST_IDLE && q_pop && head.cmd == CMD_WALK, state_ff == ST_LOOK && level_ff == LVL_1GB)

endmodule

// File: dv/sv39ptw_checker.sv
// Scoreboard for the Sv39 page-table walker: mirrors the table store and the
// root register, predicts every translation and checks the response channel.
// Depends on sv39ptw_pkg and the channel interfaces in sv39ptw_ifs.
module sv39ptw_checker (
   input  logic                           clock,
   input  logic                           reset,
   sv39ptw_req_if                         req,
   sv39ptw_rsp_if                         rsp,
   input  logic                           csr_wr_en,
   input  logic [sv39ptw_pkg::ROOT_W-1:0] csr_wr_data,
   output int                             outstanding,
   output int                             failures
);
   import sv39ptw_pkg::*;

   localparam int OFFSET_W = 12;

   typedef struct packed {
      logic               fault;
      logic [PA_W-1:0]    pa;
      logic               global_page;
      logic [LEVEL_W-1:0] level;
   } xlate_result_type;

   typedef struct {
      logic [VA_W-1:0]  va;
      xlate_result_type result;
   } xlate_expect_type;

   logic [PTE_W-1:0]  table_mem [DEPTH];
   logic [ROOT_W-1:0] root_page;
   xlate_expect_type  xlate_q [$];
   int                fail_cnt;

   // Three-level walk from the root page; every exit but a legal leaf is a fault
   function automatic xlate_result_type walk_table(input logic [VA_W-1:0] va);
      xlate_result_type res;
      logic [PPN_W-1:0] page;
      logic [PPN_W-1:0] ppn;
      logic [PTE_W-1:0] pte;
      logic [VA_W-1:0]  span_mask;
      logic [IDX_W-1:0] idx;
      int               lvl;
      res = '0;
      res.fault = 1'b1;
      page = PPN_W'(root_page);
      if (page >= PAGES) return res;
      for (lvl = 2; lvl >= 0; lvl--) begin
         idx = va[OFFSET_W + 9*lvl +: IDX_W];
         pte = table_mem[int'(page) * SLOTS + int'(idx)];
         ppn = pte[PPN_LSB +: PPN_W];
         if (!pte[PTE_V]) return res;
         if (pte[PTE_X:PTE_R] == '0) begin
            // pointer: full PPN must land inside the store
            if (ppn >= PAGES) return res;
            page = ppn;
         end else begin
            // writable without readable is reserved
            if (pte[PTE_W_B] && !pte[PTE_R]) return res;
            // superpage needs its low PPN bits clear
            if (lvl > 0 && (ppn & ((PPN_W'(1) << (9*lvl)) - PPN_W'(1))) != '0) return res;
            span_mask = (VA_W'(1) << (OFFSET_W + 9*lvl)) - VA_W'(1);
            res.fault       = 1'b0;
            res.pa          = {ppn, 12'h000} | PA_W'(va & span_mask);
            res.global_page = pte[PTE_G];
            res.level       = LEVEL_W'(lvl);
            return res;
         end
      end
      // pointer found at the last level
      return res;
   endfunction

   always @(posedge clock) begin
      xlate_expect_type head;
      xlate_result_type got;
      if (reset) begin
         foreach (table_mem[i]) table_mem[i] = '0;
         root_page = '0;
         xlate_q.delete();
         fail_cnt = 0;
      end else begin
         if (csr_wr_en) root_page = csr_wr_data;

         // responses first: a request accepted at this edge cannot be answered yet
         if (rsp.valid && rsp.ready) begin
            got.fault       = rsp.fault;
            got.pa          = rsp.physical_address;
            got.global_page = rsp.global_page;
            got.level       = rsp.leaf_level;
            if (xlate_q.size() == 0) begin
               fail_cnt++;
               $display("%0t: response with no translate pending: %s %0d %s %h %s %0d %s %0d",
                        $time, "fault", got.fault, "pa", got.pa, "g", got.global_page,
                        "lvl", got.level);
            end else begin
               head = xlate_q.pop_front();
               if (got.fault !== head.result.fault || got.pa !== head.result.pa ||
                   got.global_page !== head.result.global_page ||
                   got.level !== head.result.level) begin
                  fail_cnt++;
                  $display("%0t: va %h expected fault %0d pa %h g %0d lvl %0d,",
                           $time, head.va, head.result.fault, head.result.pa,
                           head.result.global_page, head.result.level);
                  $display("%0t:    got fault %0d pa %h g %0d lvl %0d",
                           $time, got.fault, got.pa, got.global_page, got.level);
               end
            end
         end

         // accepted request: update the store or queue a prediction
         if (req.valid && req.ready) begin
            if (req.kind == KIND_WRITE) begin
               if (req.page_number < PAGES)
                  table_mem[int'(req.page_number) * SLOTS + int'(req.entry_index)] =
                     req.entry_value;
            end else begin
               head.va     = req.virtual_address;
               head.result = walk_table(req.virtual_address);
               xlate_q.push_back(head);
            end
         end
      end
      outstanding <= xlate_q.size();
      failures    <= fail_cnt;
   end

endmodule

// File: dv/tb_top.sv
// Testbench top for the Sv39 page-table walker: clock, reset, request and
// root-register stimulus, pacing of both channels, watchdog and verdict.
// Depends on sv39ptw_pkg, sv39ptw_ifs, the walker RTL and sv39ptw_checker.
module tb_top;
   import sv39ptw_pkg::*;

   localparam int IDLE_LIMIT   = 30000;  // covers the store clear after reset
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_ITEMS  = 175;
   localparam int PHASES       = 8;
   localparam int OFFSET_W     = 12;

   localparam logic [7:0] F_V = 8'd1 << PTE_V;
   localparam logic [7:0] F_R = 8'd1 << PTE_R;
   localparam logic [7:0] F_W = 8'd1 << PTE_W_B;
   localparam logic [7:0] F_X = 8'd1 << PTE_X;
   localparam logic [7:0] F_G = 8'd1 << PTE_G;

   typedef enum logic [1:0] {
      PACE_FULL,
      PACE_SRC_IDLE,
      PACE_SNK_STALL,
      PACE_BOTH
   } pace_t;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [ROOT_W-1:0] csr_wr_data;
   logic [ROOT_W-1:0] root_now;
   int                xlate_pending;
   int                fail_count;
   int                src_idle_pct;
   int                snk_stall_pct;
   int                sent_count;
   int                quiet_cycles;

   sv39ptw_req_if req_ch();
   sv39ptw_rsp_if rsp_ch();

   sv39_page_table_walker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sv39ptw_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .outstanding (xlate_pending),
      .failures    (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response side back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [PTE_W-1:0] pte_of(input logic [PPN_W-1:0] ppn,
                                                input logic [7:0] flags);
      return {10'h000, ppn, 2'b00, flags};
   endfunction

   // Valid non-leaf entry with random spare bits
   function automatic logic [PTE_W-1:0] pointer_pte(input logic [PPN_W-1:0] ppn);
      logic [PTE_W-1:0] pte;
      pte = {$urandom, $urandom};
      pte[PPN_LSB +: PPN_W] = ppn;
      pte[PTE_X:PTE_R] = 3'b000;
      pte[PTE_V] = 1'b1;
      return pte;
   endfunction

   // Legal leaf, PPN aligned to the page size of its level
   function automatic logic [PTE_W-1:0] leaf_pte(input int level);
      logic [PTE_W-1:0] pte;
      logic [PPN_W-1:0] ppn;
      logic [2:0]       xwr;
      pte = {$urandom, $urandom};
      ppn = PPN_W'({$urandom, $urandom});
      ppn = ppn & ~((PPN_W'(1) << (9*level)) - 1);
      xwr = 3'($urandom_range(1, 7));
      if (xwr[1] && !xwr[0]) xwr[0] = 1'b1;  // keep R when W is set
      pte[PPN_LSB +: PPN_W] = ppn;
      pte[PTE_X:PTE_R] = xwr;
      pte[PTE_V] = 1'b1;
      return pte;
   endfunction

   // Broken or odd entries that steer the walk into its fault paths
   function automatic logic [PTE_W-1:0] noise_pte();
      logic [PTE_W-1:0] pte;
      logic [PPN_W-1:0] ppn;
      pte = {$urandom, $urandom};
      case ($urandom_range(4))
         1: begin
            // pointer whose low 32 PPN bits look in range
            ppn = PPN_W'({$urandom, $urandom});
            ppn[31:4] = '0;
            ppn[32 + $urandom_range(PPN_W - 33)] = 1'b1;
            pte = pointer_pte(ppn);
         end
         2: begin
            pte[PTE_V]   = 1'b1;
            pte[PTE_R]   = 1'b0;
            pte[PTE_W_B] = 1'b1;
         end
         3: begin
            pte = leaf_pte(0);
            pte[PPN_LSB] = 1'b1;  // misaligned for any superpage
         end
         4: pte[PTE_V] = 1'b0;
         default: ;
      endcase
      return pte;
   endfunction

   task automatic set_pace(input pace_t pace);
      case (pace)
         PACE_FULL:      begin src_idle_pct = 0;  snk_stall_pct = 0;  end
         PACE_SRC_IDLE:  begin src_idle_pct = 82; snk_stall_pct = 0;  end
         PACE_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 82; end
         PACE_BOTH:      begin src_idle_pct = 21; snk_stall_pct = 21; end
      endcase
   endtask

   // One request on the input channel, with a random gap ahead of it
   task automatic send_req(input logic kind, input logic [PGNUM_W-1:0] page,
                           input logic [IDX_W-1:0] idx, input logic [PTE_W-1:0] value,
                           input logic [VA_W-1:0] va);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.kind            <= kind;
      req_ch.page_number     <= page;
      req_ch.entry_index     <= idx;
      req_ch.entry_value     <= value;
      req_ch.virtual_address <= va;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent_count++;
   endtask

   task automatic write_entry(input logic [PGNUM_W-1:0] page, input logic [IDX_W-1:0] idx,
                              input logic [PTE_W-1:0] value);
      send_req(KIND_WRITE, page, idx, value, VA_W'({$urandom, $urandom}));
   endtask

   task automatic translate(input logic [VA_W-1:0] va);
      send_req(KIND_XLATE, PGNUM_W'($urandom), IDX_W'($urandom),
               {$urandom, $urandom}, va);
   endtask

   // Build a walk path for a random address, then translate inside it
   task automatic map_and_walk();
      logic [VA_W-1:0]    va;
      logic [VA_W-1:0]    mask;
      logic [PGNUM_W-1:0] page;
      logic [PGNUM_W-1:0] next;
      logic [PTE_W-1:0]   pte;
      int                 leaf_lvl;
      int                 lvl;
      va = VA_W'({$urandom, $urandom});
      leaf_lvl = $urandom_range(2);
      page = (root_now < PAGES) ? PGNUM_W'(root_now) : PGNUM_W'($urandom_range(PAGES - 1));
      for (lvl = 2; lvl >= leaf_lvl; lvl--) begin
         next = PGNUM_W'($urandom_range(PAGES - 1));
         if ($urandom_range(9) == 0) pte = noise_pte();
         else if (lvl > leaf_lvl) pte = pointer_pte(PPN_W'(next));
         else pte = leaf_pte(lvl);
         write_entry(page, va[OFFSET_W + 9*lvl +: IDX_W], pte);
         page = next;
      end
      mask = (VA_W'(1) << (OFFSET_W + 9*leaf_lvl)) - 1;
      repeat ($urandom_range(1, 3)) translate(va ^ (VA_W'({$urandom, $urandom}) & mask));
   endtask

   // Wait until no translation is pending and queued writes have landed
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (xlate_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_root(input logic [ROOT_W-1:0] root);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= root;
      root_now     = root;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int                phase;
      int                goal;
      int                pick;
      logic [ROOT_W-1:0] root;
      reset                  <= 1'b1;
      csr_wr_en              <= 1'b0;
      csr_wr_data            <= '0;
      req_ch.valid           <= 1'b0;
      req_ch.kind            <= KIND_WRITE;
      req_ch.page_number     <= '0;
      req_ch.entry_index     <= '0;
      req_ch.entry_value     <= '0;
      req_ch.virtual_address <= '0;
      root_now      = '0;
      sent_count    = 0;
      set_pace(PACE_FULL);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: root page 0 after reset
      translate('0);                                          // empty store
      write_entry(4'd0, 9'd0, pte_of(44'd1, F_V));
      write_entry(4'd1, 9'd0, pte_of(44'd15, F_V));           // top page of store
      write_entry(4'd15, 9'd0, '1);                           // all-ones 4 KiB leaf
      translate({9'd0, 9'd0, 9'd0, 12'hFFF});
      write_entry(4'd15, 9'd1, pte_of(44'd3, F_V));           // pointer at level 0
      translate({9'd0, 9'd0, 9'd1, 12'h000});
      write_entry(4'd0, 9'd511, pte_of(44'h3 << 18, F_V | F_R | F_G));
      translate('1);                                          // 1 GiB leaf
      write_entry(4'd0, 9'd1, pte_of(44'd1, F_V | F_R | F_X)); // misaligned 1 GiB
      translate({9'd1, 30'h2AAA_5555});
      write_entry(4'd0, 9'd2, pte_of(44'hABC, F_V | F_W));    // W without R
      translate({9'd2, 30'h0000_1234});
      write_entry(4'd0, 9'd3, pte_of(PPN_W'(PAGES), F_V));    // next page beyond store
      translate({9'd3, 30'h1555_AAAA});
      write_entry(4'd0, 9'd4, pte_of(44'h1_0000_0001, F_V | F_G)); // upper PPN bits set
      translate({9'd4, 30'h0});
      write_entry(4'd0, 9'd5, pte_of(44'd2, F_V | F_G));      // pointer G is ignored
      write_entry(4'd2, 9'd0, pte_of(44'h200, F_V | F_X));    // 2 MiB leaf
      write_entry(4'd2, 9'd1, pte_of(44'h201, F_V | F_R | F_W)); // misaligned 2 MiB
      translate({9'd5, 9'd0, 21'h1A_BCDE});
      translate({9'd5, 9'd1, 21'h0});
      write_entry(4'd0, 9'd6, 64'hFFFF_FFFF_FFFF_FFFE);       // invalid, rest set
      translate({9'd6, 30'h3FFF_FFFF});

      // Random phases: root setting and pacing change per phase
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0:       root = '0;
            1:       root = ROOT_W'(PAGES - 1);
            2:       root = '1;
            4:       root = ROOT_W'(PAGES);
            default: root = ROOT_W'($urandom_range(PAGES - 1));
         endcase
         set_root(root);
         set_pace(pace_t'(phase % 4));
         goal = sent_count + PHASE_ITEMS;
         while (sent_count < goal) begin
            pick = $urandom_range(99);
            if (pick < 80) map_and_walk();
            else if (pick < 90)
               write_entry(PGNUM_W'($urandom), IDX_W'($urandom), noise_pte());
            else translate(VA_W'({$urandom, $urandom}));
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/sv39ptw_pkg.sv
rtl/sv39ptw_ifs.sv
rtl/sv39ptw_front.sv
rtl/sv39ptw_queue.sv
rtl/sv39ptw_back.sv
rtl/sv39_page_table_walker.sv
dv/sv39ptw_checker.sv
dv/tb_top.sv
